>>> rtl/pst_pkg.sv
// Shared constants and types for the partition series table.
// Used by pst_engine and partition_series_table; depends on nothing else.
`timescale 1ns / 1ps

package pst_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LIMIT_W     = 12;
	localparam int COEF_W      = 30;
	localparam logic [COEF_W-1:0] PRIME_MOD = 30'd1000000007;

	// Operation codes handed from the top level to the engine.
	localparam logic [1:0] OP_BUILD = 2'd0;
	localparam logic [1:0] OP_MUL   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] weight;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] lim;
		logic              zero;
	} pst_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [COEF_W-1:0] coef;
	} pst_res_t;

	// The highest index kept is the register value, clipped to the table.
	function automatic logic [ADDR_W-1:0] eff_limit(input logic [LIMIT_W-1:0] t);
		if (32'(t) > TABLE_DEPTH - 1) begin
			return ADDR_W'(TABLE_DEPTH - 1);
		end
		return ADDR_W'(t);
	endfunction

endpackage

>>> rtl/pst_engine.sv
// Sequencer and coefficient memory of the partition series table.
// Depends on pst_pkg.
`timescale 1ns / 1ps

module pst_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pst_pkg::pst_cmd_t cmd,
	output logic              idle,
	output pst_pkg::pst_res_t res,
	input  logic              res_ready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_BSUM  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	localparam int AW = pst_pkg::ADDR_W;
	localparam int CW = pst_pkg::COEF_W;

	function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, pst_pkg::PRIME_MOD}) begin
			s = s - {1'b0, pst_pkg::PRIME_MOD};
		end
		return s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] mod_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + {1'b0, pst_pkg::PRIME_MOD} - {1'b0, b};
		end
		return s[CW-1:0];
	endfunction

	logic [CW-1:0] mem [pst_pkg::TABLE_DEPTH];
	logic [CW-1:0] rda_q, rdb_q;

	logic [2:0]    state_q;
	logic [AW-1:0] lim_q, i_q, j_q, w_q, k_q, addr_s1;
	logic [AW:0]   g_q;
	logic          sec_q, zero_q, pend_s1, neg_s1, m_s1;
	logic [CW-1:0] acc_q;

	logic          we, rea, reb, g_ok;
	logic [AW-1:0] wa, aa, ab;
	logic [CW-1:0] wd;

	assign g_ok = g_q <= {1'b0, i_q};

	always_comb begin
		we  = 1'b0;
		wa  = i_q;
		wd  = acc_q;
		rea = 1'b0;
		aa  = j_q;
		reb = 1'b0;
		ab  = j_q - w_q;
		case (state_q)
			ST_IDLE: begin
				if (start && cmd.op == pst_pkg::OP_BUILD) begin
					we = 1'b1;
					wa = '0;
					wd = CW'(1);
				end else if (start && cmd.op == pst_pkg::OP_READ && !cmd.zero) begin
					rea = 1'b1;
					aa  = cmd.addr;
				end
			end
			ST_BSUM: begin
				if (g_ok) begin
					rea = 1'b1;
					aa  = i_q - g_q[AW-1:0];
				end else if (!pend_s1) begin
					we = 1'b1;
				end
			end
			ST_MUL: begin
				rea = 1'b1;
				reb = 1'b1;
				we  = m_s1;
				wa  = addr_s1;
				wd  = mod_sub(rda_q, rdb_q);
			end
			ST_DRAIN: begin
				we = m_s1;
				wa = addr_s1;
				wd = mod_sub(rda_q, rdb_q);
			end
			default: begin
			end
		endcase
	end

	// Coefficient memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rea) begin
			rda_q <= mem[aa];
		end
		if (reb) begin
			rdb_q <= mem[ab];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_s1 <= 1'b0;
			m_s1    <= 1'b0;
			lim_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			w_q     <= '0;
			k_q     <= '0;
			g_q     <= '0;
			sec_q   <= 1'b0;
			zero_q  <= 1'b0;
			neg_s1  <= 1'b0;
			addr_s1 <= '0;
			acc_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					m_s1    <= 1'b0;
					if (start) begin
						lim_q  <= cmd.lim;
						zero_q <= cmd.zero;
						case (cmd.op)
							pst_pkg::OP_BUILD: begin
								i_q   <= AW'(1);
								g_q   <= (AW+1)'(1);
								k_q   <= AW'(1);
								sec_q <= 1'b0;
								acc_q <= '0;
								if (cmd.lim != '0) begin
									state_q <= ST_BSUM;
								end
							end
							pst_pkg::OP_MUL: begin
								j_q     <= cmd.lim;
								w_q     <= cmd.weight;
								state_q <= ST_MUL;
							end
							pst_pkg::OP_READ: begin
								state_q <= ST_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BSUM: begin
					if (pend_s1) begin
						acc_q <= neg_s1 ? mod_sub(acc_q, rda_q) : mod_add(acc_q, rda_q);
					end
					if (g_ok) begin
						pend_s1 <= 1'b1;
						neg_s1  <= ~k_q[0];
						if (!sec_q) begin
							g_q   <= g_q + {1'b0, k_q};
							sec_q <= 1'b1;
						end else begin
							g_q   <= g_q + {k_q, 1'b1};
							k_q   <= k_q + AW'(1);
							sec_q <= 1'b0;
						end
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							if (i_q == lim_q) begin
								state_q <= ST_IDLE;
							end else begin
								i_q   <= i_q + AW'(1);
								g_q   <= (AW+1)'(1);
								k_q   <= AW'(1);
								sec_q <= 1'b0;
								acc_q <= '0;
							end
						end
					end
				end
				ST_MUL: begin
					m_s1    <= 1'b1;
					addr_s1 <= j_q;
					if (j_q == w_q) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q - AW'(1);
					end
				end
				ST_DRAIN: begin
					m_s1    <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle      = state_q == ST_IDLE;
	assign res.valid = state_q == ST_RD;
	assign res.coef  = zero_q ? '0 : rda_q;

	// A summation read in flight always comes from the build walk.
	a_pend_from_build: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q) == ST_BSUM)
		else $error("summation read pending outside build");

	// The multiply write trails its read by exactly one entry.
	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && m_s1) |-> addr_s1 == j_q + AW'(1))
		else $error("multiply write not one entry above read");

	// A build ends only after the last kept entry is written.
	a_build_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_BSUM) |-> $past(i_q) == lim_q)
		else $error("build ended early");

	// No entry above the limit is ever written.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != ST_IDLE) |-> wa <= lim_q)
		else $error("write above limit");

endmodule

>>> rtl/partition_series_table.sv
// Top level of the partition series table: stream ports, limit register, result register.
// Depends on pst_pkg and pst_engine.
`timescale 1ns / 1ps

// Channel   Direction  Payload (lowest bit first)           Transfer when
// s_*       in         cmd[1:0] weight[13:2] index[25:14]   s_tvalid & s_tready
// m_*       out        coefficient[29:0]                    m_tvalid & m_tready
// cfg_*     in         term_limit[11:0]                     cfg_valid & cfg_ready
//
// Items are handled one at a time; s_tready is high whenever the sequencer is idle.
// A read passes through the memory read, then the result register, and an ignored
// command leaves the sequencer idle. A multiply by (1 - x^w) rewrites one memory entry
// per cycle, from the limit down to w, through the dual-read, single-write table, then
// drains the last write and returns to idle. A build writes 1 into entry 0, then for
// each index i from 1 to the limit reads one entry per generalized pentagonal number
// up to i, then finishes the signed sum and writes it into entry i.
// Reset clears control state and sets the limit to 4095; the table contents are
// undefined until a build. A result waiting on m_tready does not block the next
// input transfer, only a following read result.

module partition_series_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // cmd[1:0], weight[13:2], index[25:14], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // coefficient[29:0], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);

	localparam int AW = pst_pkg::ADDR_W;

	logic [pst_pkg::LIMIT_W-1:0] term_limit_q;
	logic [AW-1:0]               lim;
	logic [1:0]                  in_cmd;
	logic [11:0]                 in_weight, in_index;
	pst_pkg::pst_cmd_t           cmd;
	pst_pkg::pst_res_t           res;
	logic                        eng_idle, start, res_ready;
	logic                        m_valid_q;
	logic [pst_pkg::COEF_W-1:0]  m_coef_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_limit_q <= 12'd4095;
		end else if (cfg_valid) begin
			term_limit_q <= cfg_data;
		end
	end

	assign lim       = pst_pkg::eff_limit(term_limit_q);
	assign in_cmd    = s_tdata[1:0];
	assign in_weight = s_tdata[13:2];
	assign in_index  = s_tdata[25:14];

	// Commands that cannot change anything (zero or oversized weight, unknown
	// code) are turned into no-ops here so the engine never sees them.
	always_comb begin
		cmd.weight = AW'(in_weight);
		cmd.addr   = AW'(in_index);
		cmd.lim    = lim;
		cmd.zero   = 32'(in_index) > 32'(lim);
		case (in_cmd)
			pst_pkg::OP_BUILD: cmd.op = pst_pkg::OP_BUILD;
			pst_pkg::OP_MUL: begin
				if (in_weight == '0 || 32'(in_weight) > 32'(lim)) begin
					cmd.op = pst_pkg::OP_NONE;
				end else begin
					cmd.op = pst_pkg::OP_MUL;
				end
			end
			pst_pkg::OP_READ: cmd.op = pst_pkg::OP_READ;
			default: cmd.op = pst_pkg::OP_NONE;
		endcase
	end

	assign s_tready  = eng_idle;
	assign start     = s_tvalid && eng_idle;
	assign res_ready = !m_valid_q || m_tready;

	pst_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.idle      (eng_idle),
		.res       (res),
		.res_ready (res_ready)
	);

	// Result register: loaded when the engine presents a read and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			m_coef_q <= res.coef;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_coef_q};

endmodule
